FILE: rtl/bpadm_pkg.sv
package bpadm_pkg;

   // Design constants
   localparam int MAX_PATTERN = 32;
   localparam int DIST        = 3;

   // Derived widths
   localparam int ROW_W    = DIST + 1;
   localparam int IDX_W    = $clog2(MAX_PATTERN);
   localparam int TEXT_W   = 4;
   localparam int FLAG_W   = 4;
   localparam int SYM_W    = 2;
   localparam int PAT_W    = 64;
   localparam int LEN_W    = 6;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 64;

   // Highest flag that can be reported within the result field
   localparam int FLAG_LIM = (DIST < FLAG_W - 1) ? DIST : FLAG_W - 1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_SYMBOLS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH  = CSR_IDX_W'(1);

   // One slot of the cell chain
   typedef struct packed {
      logic              valid;
      logic [TEXT_W-1:0] text;
      logic [ROW_W-1:0]  cur_row;   // grid row of this position, from the upstream cell
      logic [ROW_W-1:0]  prev_row;  // same row from the previous position
      logic [ROW_W-1:0]  sel_row;   // row at the last pattern symbol, once passed
   } bpadm_stage_type;

   // Exact-edit flags from the last pattern row
   function automatic logic [FLAG_W-1:0] match_flags_of(logic [ROW_W-1:0] row);
      logic [FLAG_W-1:0] f;
      f    = '0;
      f[0] = row[0];
      for (int k = 1; k <= FLAG_LIM; k++) begin
         f[k] = row[k] & ~row[k-1];
      end
      return f;
   endfunction

endpackage

FILE: rtl/bpadm_if.sv
interface bpadm_req_if;
   import bpadm_pkg::*;

   logic              valid;
   logic              ready;
   logic [TEXT_W-1:0] text_classes;

   modport source (output valid, output text_classes, input ready);
   modport sink   (input valid, input text_classes, output ready);
endinterface

interface bpadm_rsp_if;
   import bpadm_pkg::*;

   logic              valid;
   logic              ready;
   logic [FLAG_W-1:0] match_flags;

   modport source (output valid, output match_flags, input ready);
   modport sink   (input valid, input match_flags, output ready);
endinterface

FILE: rtl/bit_parallel_approx_dna_match_core.sv
// Channel  Dir  Payload                Transfer when
// req      in   text_classes [3:0]     req_ch.valid & req_ch.ready
// rsp      out  match_flags  [3:0]     rsp_ch.valid & rsp_ch.ready
// csr      in   csr_index, csr_wdata   csr_wr_en
//
// One text position per cycle while the result is not stalled. An input transfer
// loads the first cell, each advance moves the position one cell down, and the
// advance after the last cell loads the result register.
// Synchronous active-high reset clears the stored grid rows and all valids.
// A stalled result freezes the whole chain; req_ch.ready follows the result
// register (empty, or being taken this cycle).
module bit_parallel_approx_dna_match_core (
   input  logic                                clock,
   input  logic                                reset,
   bpadm_req_if.sink                           req_ch,
   bpadm_rsp_if.source                         rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [bpadm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpadm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bpadm_pkg::*;

   logic [PAT_W-1:0]  pattern_symbols_ff;
   logic [LEN_W-1:0]  pattern_length_ff;
   logic [IDX_W-1:0]  sel_idx;
   logic              advance;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FLAG_W-1:0] rsp_flags_ff, rsp_flags_in;
   bpadm_stage_type   head;
   bpadm_stage_type   chain [MAX_PATTERN];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_symbols_ff <= '0;
         pattern_length_ff  <= LEN_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_SYMBOLS: pattern_symbols_ff <= csr_wdata[PAT_W-1:0];
            CSR_PATTERN_LENGTH:  pattern_length_ff  <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Row holding the last pattern symbol, with the length clamped to range
   always_comb begin
      if (pattern_length_ff == '0) begin
         sel_idx = '0;
      end else if (pattern_length_ff > LEN_W'(MAX_PATTERN)) begin
         sel_idx = IDX_W'(MAX_PATTERN - 1);
      end else begin
         sel_idx = IDX_W'(pattern_length_ff - LEN_W'(1));
      end
   end

   // Chain moves whenever the result register can take a new value
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // Virtual row above the first cell: all ones gives row 0 of the grid
   always_comb begin
      head.valid    = req_ch.valid;
      head.text     = req_ch.text_classes;
      head.cur_row  = '1;
      head.prev_row = '1;
      head.sel_row  = '0;
   end

   // Row of cells, one per pattern symbol
   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      bpadm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .sym_code (pattern_symbols_ff[SYM_W*i +: SYM_W]),
         .cell_idx (IDX_W'(i)),
         .sel_idx  (sel_idx),
         .up       ((i == 0) ? head : chain[(i == 0) ? 0 : i-1]),
         .down     (chain[i])
      );
   end

   // Result register
   always_comb begin
      rsp_valid_in = advance ? chain[MAX_PATTERN-1].valid : rsp_valid_ff;
      rsp_flags_in = advance ? match_flags_of(chain[MAX_PATTERN-1].sel_row)
                             : rsp_flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.match_flags = rsp_flags_ff;

endmodule

FILE: rtl/bpadm_cell.sv
module bpadm_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [bpadm_pkg::SYM_W-1:0]    sym_code,
   input  logic [bpadm_pkg::IDX_W-1:0]    cell_idx,
   input  logic [bpadm_pkg::IDX_W-1:0]    sel_idx,
   input  bpadm_pkg::bpadm_stage_type     up,
   output bpadm_pkg::bpadm_stage_type     down
);
   import bpadm_pkg::*;

   logic [ROW_W-1:0] prior_ff, prior_in;
   logic [ROW_W-1:0] cur;
   logic             p;
   bpadm_stage_type  stage_ff, stage_in;

   // Grid row for this pattern symbol at the incoming position
   always_comb begin
      p      = up.text[sym_code];
      cur    = '0;
      cur[0] = up.prev_row[0] & p;
      for (int j = 1; j <= DIST; j++) begin
         cur[j] = (up.prev_row[j] & p) | (up.prev_row[j-1] & ~p)
                | prior_ff[j-1] | up.cur_row[j-1];
      end
   end

   // Stored row and hand-off to the next cell
   always_comb begin
      prior_in = (advance && up.valid) ? cur : prior_ff;
      stage_in.valid    = up.valid;
      stage_in.text     = up.text;
      stage_in.cur_row  = cur;
      stage_in.prev_row = prior_ff;
      stage_in.sel_row  = (cell_idx == sel_idx) ? cur : up.sel_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff <= '0;
         stage_ff <= '0;
      end else begin
         prior_ff <= prior_in;
         if (advance) begin
            stage_ff <= stage_in;
         end
      end
   end

   assign down = stage_ff;

endmodule

FILE: rtl/bpadm_checker.sv
module bpadm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bpadm_pkg::FLAG_W-1:0] rsp_flags
);
   import bpadm_pkg::*;

   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Input is held off only while a result is blocked
   a_ready_follows_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow result stall");

   // Pipeline holds no results unless something was accepted: with no input in the
   // cycle after reset, the output stays idle
   a_no_invented: assert property (@(posedge clock)
      $past(reset) && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("result appeared without an input transfer");

   // Stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_flags))
      else $error("stalled result changed");

endmodule

bind bit_parallel_approx_dna_match_core bpadm_checker u_bpadm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_flags (rsp_ch.match_flags)
);
